### rtl/core/woc_pkg.sv
// Shared types, constants and helpers for the word occurrence counter.
package woc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_REG_W       = 5;
    localparam int LEN_W           = 8;
    localparam int OUT_COUNT_W     = 32;
    localparam int PAT_REG_BYTES   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2,
        CFG_WHOLE   = 2'd3
    } t_cfg_idx;

    // Per-cell status handed back to the top level
    typedef struct packed {
        logic match_ok;
        logic word_char;
    } t_cell_stat;

    // Letters and dash belong to a word
    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == 8'h2D);
    endfunction

endpackage

### rtl/core/woc_cell.sv
// One history cell: holds a text byte and checks the byte shifting into it.
module woc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_clear,
    input  logic [woc_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_valid,
    input  logic [woc_pkg::BYTE_W-1:0]  i_pat_byte,
    input  logic                        i_in_use,
    output logic [woc_pkg::BYTE_W-1:0]  o_byte,
    output logic                        o_valid,
    output woc_pkg::t_cell_stat         o_stat
);

    logic [woc_pkg::BYTE_W-1:0] r_byte;
    logic                       r_valid;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_clear ? '0 : i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_clear ? 1'b0 : i_valid;
        end
    end

    // A cell outside the pattern length never blocks a match
    assign o_stat.match_ok  = !i_in_use || (i_byte == i_pat_byte);
    assign o_stat.word_char = woc_pkg::is_word_char(i_byte);
    assign o_byte           = r_byte;
    assign o_valid          = r_valid;

endmodule

### rtl/core/word_occurrence_counter.sv
// Word occurrence counter: counts a configured byte pattern in a byte stream.
//
// Text bytes enter on the s_axis channel, one byte per item, with tlast on
// the final byte of a text. Every accepted item yields exactly one result
// item on m_axis: tdata carries the running count, tuser flags that this item
// confirmed an occurrence, tlast marks the count that covers the whole text.
// In whole-word mode a match is confirmed by the byte after it, so its count
// shows up on the following item (or on the same item at end of text).
// The result is registered and valid in the cycle after acceptance; throughput
// is one item per cycle while the receiver does not stall. A row of
// MAX_PATTERN+1 cells holds the byte history and compares all positions in parallel,
// so the rate is set by that single compare-and-count path, not by any loop.
// The pattern is written through the cfg port (index 0/1 pattern bytes,
// 2 length, 3 whole-word mode) between items.
// Reset clears history, count and config (length 1, plain mode). When the
// receiver stalls the result is held in the output register and s_axis_tready
// drops until it is taken; an item is still accepted in the cycle the held
// result leaves. After a tlast item all text state returns to zero.
module word_occurrence_counter #(
    parameter int MAX_PATTERN = woc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = woc_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [woc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [woc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] text_byte
    input  logic                              s_axis_tlast,   // end_of_text
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] occurrence_count
    output logic                              m_axis_tuser,   // occurrence_found
    output logic                              m_axis_tlast    // count_final
);

    localparam int NCELL  = MAX_PATTERN + 1;
    localparam int SEL_W  = $clog2(NCELL);
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int BW     = woc_pkg::BYTE_W;
    localparam int LW     = woc_pkg::LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration
    logic [woc_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [woc_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [woc_pkg::LEN_REG_W-1:0]  r_pat_len;
    logic                           r_whole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= woc_pkg::LEN_REG_W'(1);
            r_whole   <= 1'b0;
        end else if (i_cfg_we) begin
            case (woc_pkg::t_cfg_idx'(i_cfg_index))
                woc_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_wdata;
                woc_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_wdata;
                woc_pkg::CFG_PAT_LEN: r_pat_len <= i_cfg_wdata[woc_pkg::LEN_REG_W-1:0];
                woc_pkg::CFG_WHOLE:   r_whole   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp length to 1..MAX_PATTERN
    logic [LW-1:0] len_raw;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] len_m1;

    assign len_raw = LW'(r_pat_len);
    always_comb begin
        if (len_raw == '0) begin
            len_eff = LW'(1);
        end else if (len_raw > LW'(MAX_PATTERN)) begin
            len_eff = LW'(MAX_PATTERN);
        end else begin
            len_eff = len_raw;
        end
    end
    assign len_m1 = len_eff - LW'(1);

    // Pattern bytes; positions past the two registers read as zero
    logic [BW-1:0] pat_bytes [MAX_PATTERN];

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
        if (j < woc_pkg::PAT_REG_BYTES) begin : g_lo
            assign pat_bytes[j] = r_pat_lo[j*BW +: BW];
        end else if (j < 2 * woc_pkg::PAT_REG_BYTES) begin : g_hi
            assign pat_bytes[j] = r_pat_hi[(j - woc_pkg::PAT_REG_BYTES)*BW +: BW];
        end else begin : g_zero
            assign pat_bytes[j] = '0;
        end
    end

    // Handshake
    logic r_out_valid;
    logic fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    // Cell row: cell k sees the byte that lands at history position k
    logic [BW-1:0]       chain_byte  [NCELL+1];
    logic                chain_valid [NCELL+1];
    woc_pkg::t_cell_stat cell_stat   [NCELL];
    logic [NCELL-1:0]    cell_ok;
    logic [NCELL-1:0]    in_valid;
    logic [NCELL-1:0]    in_word;

    assign chain_byte[0]  = s_axis_tdata;
    assign chain_valid[0] = 1'b1;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic [LW-1:0] pidx;
        logic [BW-1:0] pat_k;
        logic          in_use;

        assign pidx   = len_m1 - LW'(k);
        assign in_use = (LW'(k) < len_eff);
        if (k < MAX_PATTERN) begin : g_sel
            assign pat_k = pat_bytes[pidx[PIDX_W-1:0]];
        end else begin : g_none
            assign pat_k = '0;
        end

        woc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (fire),
            .i_clear    (s_axis_tlast),
            .i_byte     (chain_byte[k]),
            .i_valid    (chain_valid[k]),
            .i_pat_byte (pat_k),
            .i_in_use   (in_use),
            .o_byte     (chain_byte[k+1]),
            .o_valid    (chain_valid[k+1]),
            .o_stat     (cell_stat[k])
        );

        assign cell_ok[k]  = cell_stat[k].match_ok;
        assign in_valid[k] = chain_valid[k];
        assign in_word[k]  = cell_stat[k].word_char;
    end

    // Match and whole-word decisions
    logic                  r_pending;
    logic [COUNT_BITS-1:0] r_count;
    logic                  pend_hit;
    logic                  match;
    logic                  bound_ok;
    logic                  new_hit;
    logic                  n_pending;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] n_count;

    assign pend_hit = r_pending && !in_word[0];
    assign match    = in_valid[len_m1[SEL_W-1:0]] && (&cell_ok);
    assign bound_ok = !in_valid[len_eff[SEL_W-1:0]] || !in_word[len_eff[SEL_W-1:0]];

    always_comb begin
        new_hit   = 1'b0;
        n_pending = 1'b0;
        if (match) begin
            if (!r_whole) begin
                new_hit = 1'b1;
            end else if (bound_ok) begin
                if (s_axis_tlast) begin
                    new_hit = 1'b1;
                end else begin
                    n_pending = 1'b1;
                end
            end
        end
    end

    // Saturating add of up to two confirmations
    assign sum     = {1'b0, r_count} + (COUNT_BITS+1)'(pend_hit) + (COUNT_BITS+1)'(new_hit);
    assign n_count = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];

    logic [woc_pkg::OUT_COUNT_W-1:0] out_count;
    if (COUNT_BITS >= woc_pkg::OUT_COUNT_W) begin : g_cnt_trunc
        assign out_count = n_count[woc_pkg::OUT_COUNT_W-1:0];
    end else begin : g_cnt_ext
        assign out_count = woc_pkg::OUT_COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_count   <= '0;
        end else if (fire) begin
            r_pending <= s_axis_tlast ? 1'b0 : n_pending;
            r_count   <= s_axis_tlast ? '0 : n_count;
        end
    end

    // Output register
    logic [woc_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic                            r_out_found;
    logic                            r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_count <= out_count;
            r_out_found <= pend_hit || new_hit;
            r_out_final <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_final;

`ifndef SYNTHESIS
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && s_axis_tlast |=> (r_count == '0) && !r_pending)
        else $error("text state not cleared after last item");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !s_axis_tlast |=> r_count >= $past(r_count))
        else $error("running count decreased inside a text");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted item produced no result");

    a_found_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !s_axis_tlast && !(pend_hit || new_hit) |=> r_count == $past(r_count))
        else $error("count changed without a confirmed occurrence");
`endif

endmodule

### sim/word_occurrence_counter_test.sv
// Self-checking stream testbench for the word occurrence counter.
`timescale 1ns / 1ps

module word_occurrence_counter_test;

    localparam int MAX_PAT   = woc_pkg::MAX_PATTERN_DEF;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_text_item;

    typedef struct packed {
        logic        found;
        logic [31:0] count;
        logic        closes_text;
    } t_count_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [woc_pkg::CFG_IDX_W-1:0]  i_cfg_index = woc_pkg::CFG_PAT_LO;
    logic [woc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    word_occurrence_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the pattern registers
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = 5'd1;
    logic        whole_words = 1'b0;

    // Text state of the predictor
    logic [7:0]  hist [0:MAX_PAT];
    int          seen_bytes = 0;
    logic        word_pending = 1'b0;
    logic [31:0] occ_count = '0;

    t_text_item    text_queue[$];
    t_count_result expected_counts[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mismatches = 0;

    initial begin
        for (int k = 0; k <= MAX_PAT; k++) hist[k] = 8'h00;
    end

    function automatic logic letter_or_dash(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "-";
    endfunction

    function automatic logic [7:0] pat_byte(input int idx);
        if (idx < 8) return pat_lo[8*idx +: 8];
        if (idx < 16) return pat_hi[8*(idx-8) +: 8];
        return 8'h00;
    endfunction

    function automatic int eff_len();
        int n;
        n = int'(pat_len);
        if (n == 0) n = 1;
        if (n > MAX_PAT) n = MAX_PAT;
        return n;
    endfunction

    function automatic void bump_occ();
        if (occ_count != '1) occ_count = occ_count + 1;
    endfunction

    // Advance the text by one byte and return the count item it produces
    function automatic t_count_result count_step(input logic [7:0] b, input logic last);
        t_count_result r;
        int  n;
        int  k;
        logic hit;
        n = eff_len();
        r.found = 1'b0;
        if (word_pending && !letter_or_dash(b)) begin
            bump_occ();
            r.found = 1'b1;
        end
        word_pending = 1'b0;
        for (k = MAX_PAT; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = b;
        if (seen_bytes < MAX_PAT + 1) seen_bytes++;
        hit = (seen_bytes >= n);
        for (k = 0; hit && k < n; k++) begin
            if (hist[n-1-k] != pat_byte(k)) hit = 1'b0;
        end
        if (hit) begin
            if (!whole_words) begin
                bump_occ();
                r.found = 1'b1;
            end else if (seen_bytes == n || !letter_or_dash(hist[n])) begin
                if (last) begin
                    bump_occ();
                    r.found = 1'b1;
                end else begin
                    word_pending = 1'b1;
                end
            end
        end
        r.count = occ_count;
        r.closes_text = last;
        if (last) begin
            for (k = 0; k <= MAX_PAT; k++) hist[k] = 8'h00;
            seen_bytes = 0;
            word_pending = 1'b0;
            occ_count = '0;
        end
        return r;
    endfunction

    // Sender: offer queued bytes, predict on acceptance
    always @(posedge i_clk) begin : send_blk
        t_text_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_counts.push_back(count_step(s_axis_tdata, s_axis_tlast));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (text_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = text_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.eot;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served < holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_blk
        t_count_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_counts.size() == 0) begin
                $error("count item with nothing expected: count %0d", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                if (m_axis_tuser !== want.found) begin
                    $error("occurrence_found: expected %0d, got %0d", want.found, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata !== want.count) begin
                    $error("occurrence_count: expected %0d, got %0d", want.count, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.closes_text) begin
                    $error("count_final: expected %0d, got %0d", want.closes_text,
                           m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input woc_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            woc_pkg::CFG_PAT_LO:  pat_lo = val;
            woc_pkg::CFG_PAT_HI:  pat_hi = val;
            woc_pkg::CFG_PAT_LEN: pat_len = val[4:0];
            woc_pkg::CFG_WHOLE:   whole_words = val[0];
            default: ;
        endcase
    endtask

    task automatic push_str(input string s, input logic eot_at_end);
        t_text_item it;
        for (int k = 0; k < s.len(); k++) begin
            it.ch  = s[k];
            it.eot = eot_at_end && (k == s.len() - 1);
            text_queue.push_back(it);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eot);
        t_text_item it;
        it.ch  = b;
        it.eot = eot;
        text_queue.push_back(it);
    endtask

    // Wait until every queued byte has its count item back
    task automatic drain_all();
        while (text_queue.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1)) return 8'($urandom_range(90, 65));
        return 8'($urandom_range(122, 97));
    endfunction

    function automatic logic [7:0] rand_gap();
        case ($urandom_range(5))
            0: return " ";
            1: return ".";
            2: return ",";
            3: return 8'h0A;
            4: return 8'h00;
            default: begin
                logic [7:0] c;
                c = 8'($urandom_range(255));
                return letter_or_dash(c) ? 8'hFF : c;
            end
        endcase
    endfunction

    task automatic pick_pattern();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  b;
        logic [4:0]  len;
        int          sel;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 70)      len = 5'($urandom_range(6, 1));
        else if (sel < 80) len = 5'd16;
        else if (sel < 90) len = 5'($urandom_range(15, 7));
        else if (sel < 95) len = 5'd0;
        else               len = 5'($urandom_range(31, 17));
        for (int k = 0; k < 16; k++) begin
            sel = $urandom_range(99);
            if (sel < 70)      b = rand_letter();
            else if (sel < 80) b = "-";
            else if (sel < 85) b = rand_gap();
            else               b = 8'($urandom_range(255));
            if (k < 8) lo[8*k +: 8] = b;
            else       hi[8*(k-8) +: 8] = b;
        end
        write_reg(woc_pkg::CFG_PAT_LO, lo);
        write_reg(woc_pkg::CFG_PAT_HI, hi);
        write_reg(woc_pkg::CFG_PAT_LEN, {59'd0, len});
        write_reg(woc_pkg::CFG_WHOLE, 64'($urandom_range(1)));
    endtask

    // Build one text rich in pattern copies and word boundaries
    task automatic queue_text(output int added);
        logic [7:0] chars[$];
        t_text_item it;
        int span;
        int n;
        int sel;
        span = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
        n = eff_len();
        while (chars.size() < span) begin
            sel = $urandom_range(9);
            if (sel < 4) begin
                for (int k = 0; k < n; k++) chars.push_back(pat_byte(k));
            end else if (sel < 6) begin
                chars.push_back(rand_gap());
            end else if (sel < 8) begin
                chars.push_back($urandom_range(4) == 0 ? 8'h2D : rand_letter());
            end else if (sel < 9) begin
                chars.push_back(8'($urandom_range(255)));
            end else begin
                for (int k = 0; k < $urandom_range(n - 1); k++) chars.push_back(pat_byte(k));
            end
        end
        for (int k = 0; k < chars.size(); k++) begin
            it.ch  = chars[k];
            it.eot = (k == chars.size() - 1);
            text_queue.push_back(it);
        end
        added = chars.size();
    endtask

    initial begin : stim_blk
        int got;
        int total;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 6;
        rx_idle_pct = 76;

        // Reset pattern is a single zero byte in plain mode
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_all();

        // Zero length reads as one; a pending word and a new one both land on the last byte
        write_reg(woc_pkg::CFG_WHOLE, 64'd1);
        write_reg(woc_pkg::CFG_PAT_LEN, 64'd0);
        write_reg(woc_pkg::CFG_PAT_LO, 64'h31);
        push_str("11", 1'b1);
        drain_all();

        // Oversized length clamps to sixteen; text shorter than the pattern
        write_reg(woc_pkg::CFG_WHOLE, 64'd0);
        write_reg(woc_pkg::CFG_PAT_LO, '1);
        write_reg(woc_pkg::CFG_PAT_HI, '1);
        write_reg(woc_pkg::CFG_PAT_LEN, 64'd31);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain_all();

        // Pending whole word survives a mode change in the middle of a text
        write_reg(woc_pkg::CFG_PAT_LO, 64'h6261);
        write_reg(woc_pkg::CFG_PAT_LEN, 64'd2);
        write_reg(woc_pkg::CFG_WHOLE, 64'd1);
        push_str(" ab", 1'b0);
        drain_all();
        write_reg(woc_pkg::CFG_WHOLE, 64'd0);
        push_str(" ", 1'b1);
        drain_all();

        // Overlapping hits in plain mode
        write_reg(woc_pkg::CFG_PAT_LO, 64'h6161);
        push_str("aaaa", 1'b1);
        drain_all();

        // Word boundaries: dash after, dash before, end of text after
        write_reg(woc_pkg::CFG_PAT_LO, 64'h6261);
        write_reg(woc_pkg::CFG_WHOLE, 64'd1);
        push_str("ab-ab ab", 1'b1);
        drain_all();

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 76 : 0;
            rx_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 6 : 0;
            for (int p = 0; p < 4; p++) begin
                pick_pattern();
                total = 0;
                while (total < 80) begin
                    queue_text(got);
                    total += got;
                end
                if (mode == 2 && p == 1) holds_asked++;
                drain_all();
            end
        end

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("word_occurrence_counter_test passed");
        end else begin
            $display("word_occurrence_counter_test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("word_occurrence_counter_test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/woc_pkg.sv
rtl/core/woc_cell.sv
rtl/core/word_occurrence_counter.sv
sim/word_occurrence_counter_test.sv
